>>> rtl/hnt_pkg.sv
// Package for the heightmap normal, tangent and bitangent generator.
// Holds grid size constants, field widths and shared types; no dependencies.
package hnt_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = POS_W + 1;

    localparam int H_W      = 16;
    localparam int COMP_W   = H_W + 2;
    localparam int OUT_W    = 16;
    localparam int SQ_W     = 2 * COMP_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 64;
    localparam int LEN_W    = ROOT_W / 2;
    localparam int NUM_W    = 48;
    localparam int QUO_W    = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [OUT_W-1:0]  unit_t;

    typedef struct packed {
        comp_t a;
        comp_t b;
        comp_t c;
    } vec_t;

    typedef struct packed {
        unit_t a;
        unit_t b;
        unit_t c;
    } uvec_t;

endpackage

>>> rtl/hnt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/hnt_unit_vec.sv
// Iterative vector normalizer: squares, bitwise square root, restoring division.
// Depends on hnt_pkg.
module hnt_unit_vec
    import hnt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  vec_t  vec_in,
    output logic  done,
    output uvec_t vec_out
);

    typedef enum logic [2:0] {
        U_IDLE, U_SQ, U_PREP, U_ROOT, U_DINIT, U_DIV, U_STORE, U_DONE
    } ustate_t;

    ustate_t                 state_reg;
    logic [COMP_W-1:0]       mag_reg [3];
    logic [2:0]              neg_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [1:0]              idx_reg;
    logic [ROOT_W-1:0]       v_reg;
    logic [ROOT_W-1:0]       r_reg;
    logic [ROOT_W-1:0]       bit_reg;
    logic [4:0]              it_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [3:0]              qb_reg;
    logic [QUO_W-1:0]        q_reg;
    unit_t                   res_reg [3];
    logic                    done_reg;

    logic [COMP_W-1:0] mag_sel;
    logic [SQ_W-1:0]   sq;
    logic [ROOT_W-1:0] trial_root;
    logic [LEN_W-1:0]  len;
    logic [NUM_W:0]    trial_div;
    logic [QUO_W-1:0]  q_cap;

    assign mag_sel    = (idx_reg == 2'd0) ? mag_reg[0] :
                        (idx_reg == 2'd1) ? mag_reg[1] : mag_reg[2];
    assign sq         = mag_sel * mag_sel;
    assign trial_root = r_reg + bit_reg;
    assign len        = r_reg[LEN_W-1:0];
    assign trial_div  = {(NUM_W - LEN_W)'(0), len, 1'b0} << qb_reg;
    assign q_cap      = (q_reg > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                U_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        mag_reg[0] <= vec_in.a[COMP_W-1] ? COMP_W'(-vec_in.a) : vec_in.a;
                        mag_reg[1] <= vec_in.b[COMP_W-1] ? COMP_W'(-vec_in.b) : vec_in.b;
                        mag_reg[2] <= vec_in.c[COMP_W-1] ? COMP_W'(-vec_in.c) : vec_in.c;
                        neg_reg    <= {vec_in.c[COMP_W-1], vec_in.b[COMP_W-1],
                                       vec_in.a[COMP_W-1]};
                        sum_reg    <= '0;
                        idx_reg    <= 2'd0;
                        state_reg  <= U_SQ;
                    end
                end
                U_SQ: begin
                    sum_reg <= sum_reg + SUM_W'(sq);
                    if (idx_reg == 2'd2) begin
                        state_reg <= U_PREP;
                    end else begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                U_PREP: begin
                    v_reg     <= {sum_reg[35:0], 28'd0};
                    r_reg     <= '0;
                    bit_reg   <= ROOT_W'(1) << (ROOT_W - 2);
                    it_reg    <= 5'd31;
                    state_reg <= U_ROOT;
                end
                U_ROOT: begin
                    if (v_reg >= trial_root) begin
                        v_reg <= v_reg - trial_root;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (it_reg == 5'd0) begin
                        idx_reg   <= 2'd0;
                        state_reg <= U_DINIT;
                    end else begin
                        it_reg <= it_reg - 5'd1;
                    end
                end
                U_DINIT: begin
                    rem_reg   <= {1'b0, mag_sel, 29'd0} + {(NUM_W - LEN_W)'(0), len};
                    q_reg     <= '0;
                    qb_reg    <= 4'd15;
                    state_reg <= U_DIV;
                end
                U_DIV: begin
                    if ({1'b0, rem_reg} >= trial_div) begin
                        rem_reg        <= rem_reg - trial_div[NUM_W-1:0];
                        q_reg[qb_reg]  <= 1'b1;
                    end
                    if (qb_reg == 4'd0) begin
                        state_reg <= U_STORE;
                    end else begin
                        qb_reg <= qb_reg - 4'd1;
                    end
                end
                U_STORE: begin
                    res_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed(q_cap) : $signed(q_cap);
                    if (idx_reg == 2'd2) begin
                        done_reg  <= 1'b1;
                        state_reg <= U_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= U_DINIT;
                    end
                end
                U_DONE: begin
                    done_reg  <= 1'b0;
                    state_reg <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign vec_out.a = res_reg[0];
    assign vec_out.b = res_reg[1];
    assign vec_out.c = res_reg[2];

endmodule

>>> rtl/heightmap_normal_tangent_gen_unit.sv
// Top level of the heightmap normal, tangent and bitangent generator.
// Depends on hnt_pkg, hnt_ram and hnt_unit_vec.
//
// Channel   Direction  Handshake              Carries
// s_        in         s_valid / s_ready      height sample, raster order
// m_        out        m_valid / m_ready      vertex position, frame, last_of_run
// cfg_      in         cfg_valid / cfg_ready  grid side
//
// The row stores are read in the cycle after an item is taken.
// A border vertex is made valid from S_RD after its item is taken; an interior vertex
// runs three normalizations in turn on one shared unit, then is made valid.
// On the last row a second item follows in the cycle after the first is taken.
// Reset clears position and control and sets the side to 256; the row stores are not cleared.
// Output stalls hold the block; no new item is taken until all results are gone.
module heightmap_normal_tangent_gen_unit
    import hnt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SIDE_W-1:0]        cfg_grid_side,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [H_W-1:0]    s_height,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [POS_W-1:0]         m_col,
    output logic [POS_W-1:0]         m_row,
    output logic signed [OUT_W-1:0]  m_normal_x,
    output logic signed [OUT_W-1:0]  m_normal_y,
    output logic signed [OUT_W-1:0]  m_normal_z,
    output logic signed [OUT_W-1:0]  m_tangent_x,
    output logic signed [OUT_W-1:0]  m_tangent_y,
    output logic signed [OUT_W-1:0]  m_tangent_z,
    output logic signed [OUT_W-1:0]  m_bitangent_x,
    output logic signed [OUT_W-1:0]  m_bitangent_y,
    output logic signed [OUT_W-1:0]  m_bitangent_z,
    output logic                     m_last_of_run
);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_NRM, S_WAIT, S_OUT1, S_OUT2} state_t;

    state_t               state_reg;
    logic [SIDE_W-1:0]    side_reg;
    logic [POS_W-1:0]     col_pos_reg;
    logic [POS_W-1:0]     row_pos_reg;
    logic [POS_W-1:0]     x_reg;
    logic [POS_W-1:0]     z_reg;
    logic signed [H_W-1:0] ht_reg, hc_reg, hl_reg;
    logic signed [H_W-1:0] cur_h_reg, cur_ht_reg, cur_hc_reg, cur_hl_reg;
    vec_t                 vec_reg [3];
    logic [1:0]           vk_reg;
    logic                 m_valid_reg;
    logic                 last_reg;
    logic [POS_W-1:0]     m_col_reg, m_row_reg;
    uvec_t                n_reg, t_reg, b_reg;

    logic                  s_fire, cfg_fire;
    logic [POS_W-1:0]      col_next, row_next;
    logic                  col_wrap;
    logic [SIDE_W-1:0]     side_next;
    logic [H_W-1:0]        older_rd, newer_rd;
    logic signed [H_W-1:0] hr;
    logic                  inner, last_row;
    logic signed [H_W:0]   d_lr, d_tb, d_lc, d_bc;
    vec_t                  unit_in;
    uvec_t                 unit_out;
    logic                  unit_done;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;

    assign col_wrap = ({1'b0, col_pos_reg} + SIDE_W'(1)) >= side_reg;
    assign col_next = col_wrap ? '0 : col_pos_reg + POS_W'(1);
    always_comb begin
        row_next = row_pos_reg;
        if (col_wrap) begin
            row_next = (({1'b0, row_pos_reg} + SIDE_W'(1)) >= side_reg) ? '0
                     : row_pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        side_next = cfg_grid_side;
        if (cfg_grid_side < SIDE_MIN) begin
            side_next = SIDE_MIN;
        end else if (cfg_grid_side > SIDE_MAX) begin
            side_next = SIDE_MAX;
        end
    end

    hnt_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_older_ram (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr (col_pos_reg),
        .wdata (hc_reg),
        .raddr (col_next),
        .rdata (older_rd)
    );

    hnt_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_newer_ram (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr (col_pos_reg),
        .wdata (s_height),
        .raddr (col_next),
        .rdata (newer_rd)
    );

    assign hr       = $signed(newer_rd);
    assign inner    = (x_reg != '0) && (({1'b0, x_reg} + SIDE_W'(2)) <= side_reg)
                   && (z_reg >= POS_W'(2));
    assign last_row = ({1'b0, z_reg} + SIDE_W'(1)) == side_reg;

    assign d_lr = $signed({cur_hl_reg[H_W-1], cur_hl_reg}) - $signed({hr[H_W-1], hr});
    assign d_tb = $signed({cur_ht_reg[H_W-1], cur_ht_reg})
                - $signed({cur_h_reg[H_W-1], cur_h_reg});
    assign d_lc = $signed({cur_hl_reg[H_W-1], cur_hl_reg})
                - $signed({cur_hc_reg[H_W-1], cur_hc_reg});
    assign d_bc = $signed({cur_h_reg[H_W-1], cur_h_reg})
                - $signed({cur_hc_reg[H_W-1], cur_hc_reg});

    assign unit_in = (vk_reg == 2'd0) ? vec_reg[0] :
                     (vk_reg == 2'd1) ? vec_reg[1] : vec_reg[2];

    hnt_unit_vec u_unit_vec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_NRM),
        .vec_in  (unit_in),
        .done    (unit_done),
        .vec_out (unit_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            side_reg    <= SIDE_RESET;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_fire) begin
                        side_reg    <= side_next;
                        col_pos_reg <= '0;
                        row_pos_reg <= '0;
                    end else if (s_fire) begin
                        x_reg       <= col_pos_reg;
                        z_reg       <= row_pos_reg;
                        cur_h_reg   <= s_height;
                        cur_ht_reg  <= ht_reg;
                        cur_hc_reg  <= hc_reg;
                        cur_hl_reg  <= hl_reg;
                        hl_reg      <= hc_reg;
                        col_pos_reg <= col_next;
                        row_pos_reg <= row_next;
                        state_reg   <= S_RD;
                    end
                end
                S_RD: begin
                    ht_reg    <= $signed(older_rd);
                    hc_reg    <= $signed(newer_rd);
                    m_col_reg <= x_reg;
                    m_row_reg <= z_reg - POS_W'(1);
                    last_reg  <= !last_row;
                    if (z_reg != '0 && inner) begin
                        vec_reg[0] <= '{a: {d_lr, 1'b0}, b: COMP_W'(1024), c: {d_tb, 1'b0}};
                        vec_reg[1] <= '{a: -COMP_W'(256), b: COMP_W'(d_lc), c: '0};
                        vec_reg[2] <= '{a: '0, b: COMP_W'(d_bc), c: COMP_W'(256)};
                        vk_reg     <= 2'd0;
                        state_reg  <= S_NRM;
                    end else if (z_reg != '0) begin
                        n_reg       <= '{a: '0, b: ONE_Q14, c: '0};
                        t_reg       <= '0;
                        b_reg       <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT1;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_NRM: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (unit_done) begin
                        if (vk_reg == 2'd0) begin
                            n_reg <= unit_out;
                        end else if (vk_reg == 2'd1) begin
                            t_reg <= unit_out;
                        end else begin
                            b_reg <= unit_out;
                        end
                        if (vk_reg == 2'd2) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT1;
                        end else begin
                            vk_reg    <= vk_reg + 2'd1;
                            state_reg <= S_NRM;
                        end
                    end
                end
                S_OUT1: begin
                    if (m_ready) begin
                        if (last_row) begin
                            m_row_reg <= z_reg;
                            last_reg  <= 1'b1;
                            n_reg     <= '{a: '0, b: ONE_Q14, c: '0};
                            t_reg     <= '0;
                            b_reg     <= '0;
                            state_reg <= S_OUT2;
                        end else begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_OUT2: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_col         = m_col_reg;
    assign m_row         = m_row_reg;
    assign m_normal_x    = n_reg.a;
    assign m_normal_y    = n_reg.b;
    assign m_normal_z    = n_reg.c;
    assign m_tangent_x   = t_reg.a;
    assign m_tangent_y   = t_reg.b;
    assign m_tangent_z   = t_reg.c;
    assign m_bitangent_x = b_reg.a;
    assign m_bitangent_y = b_reg.b;
    assign m_bitangent_z = b_reg.c;
    assign m_last_of_run = last_reg;

`ifndef NO_ASSERTIONS
    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, col_pos_reg} < side_reg) && ({1'b0, row_pos_reg} < side_reg))
        else $error("grid position outside the configured side");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken before the first was processed");
`endif

endmodule
